>>> rtl/cdd_pkg.sv
// Package: date record, operation codes and month length lookup for the date decrement unit.
package cdd_pkg;

  typedef enum logic [2:0] {
    OP_DAYS       = 3'd0,
    OP_WEEKS      = 3'd1,
    OP_MONTHS     = 3'd2,
    OP_YEARS      = 3'd3,
    OP_DECADES    = 3'd4,
    OP_CENTURY    = 3'd5,
    OP_MILLENNIUM = 3'd6,
    OP_KEEP       = 3'd7
  } op_t;

  // working date plus the year's residue mod 25 (for the century leap rule)
  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         m25;
  } date_t;

  localparam logic signed [15:0] YEAR_MIN   = 16'sh8000;
  localparam logic [3:0]         MONTH_JAN  = 4'd1;
  localparam logic [3:0]         MONTH_FEB  = 4'd2;
  localparam logic [3:0]         MONTH_DEC  = 4'd12;
  localparam logic [4:0]         DAY_FIRST  = 5'd1;
  localparam logic [4:0]         M25_LAST   = 5'd24;
  localparam logic [4:0]         M25_WRAP   = 5'd17;   // 32767 mod 25
  localparam logic [5:0]         M25_BIAS   = 6'd7;    // -32768 mod 25
  localparam logic [5:0]         M25_MOD    = 6'd25;
  localparam logic [16:0]        RECIP25    = 17'd83887; // ceil(2^21 / 25)
  localparam int                 RECIP25_SH = 21;
  localparam logic [15:0]        CENTURY    = 16'd100;
  localparam logic [15:0]        MILLENNIUM = 16'd1000;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      unique case (month)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

>>> rtl/cdd_step_unit.sv
// Shared step unit: moves a date back by one day or by one month with day clamping.
module cdd_step_unit (
  input  cdd_pkg::date_t cur_i,
  input  logic           month_mode_i,
  output cdd_pkg::date_t nxt_o
);
  import cdd_pkg::*;

  logic       leap;
  logic       wrap;
  logic [3:0] prev_month;
  logic [4:0] prev_len;
  logic [4:0] m25_dec;

  assign leap       = (cur_i.year[1:0] == 2'b00) && ((cur_i.m25 != 5'd0) ||
                      (cur_i.year[3:0] == 4'b0000));
  assign wrap       = (cur_i.month == MONTH_JAN);
  assign prev_month = wrap ? MONTH_DEC : cur_i.month - 4'd1;
  assign prev_len   = days_in(prev_month, leap);
  assign m25_dec    = (cur_i.year == YEAR_MIN) ? M25_WRAP :
                      (cur_i.m25 == 5'd0) ? M25_LAST : cur_i.m25 - 5'd1;

  always_comb begin
    nxt_o = cur_i;
    if (month_mode_i || (cur_i.day <= DAY_FIRST)) begin
      nxt_o.month = prev_month;
      if (wrap) begin
        nxt_o.year = cur_i.year - 16'sd1;
        nxt_o.m25  = m25_dec;
      end
      if (month_mode_i) begin
        nxt_o.day = (cur_i.day > prev_len) ? prev_len : cur_i.day;
      end else begin
        nxt_o.day = prev_len;
      end
    end else begin
      nxt_o.day = cur_i.day - 5'd1;
    end
  end

endmodule

>>> rtl/calendar_date_decrement_unit.sv
// Top level: Gregorian date decrement unit with a sequencer around one shared step unit.
//
//   channel | ports                                              | direction
//   in      | in_valid/in_ready, operation, count, start date     | date and step request in
//   out     | out_valid/out_ready, result_year/month/day         | moved date out
//
// A day, week or month item first forms the year's residue mod 25 with one multiplier
// (INIT, then MOD), then the step unit moves the date back one day or one month per
// cycle, count times (times 7 for weeks). Year-type items go straight to DONE.
// in_ready is high only while idle; a finished result waits in the output register
// under back-pressure while the next item is accepted. Reset is synchronous, active low.
module calendar_date_decrement_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_operation,
  input  logic [14:0]         in_count,
  input  logic signed [15:0]  in_start_year,
  input  logic [3:0]          in_start_month,
  input  logic [4:0]          in_start_day,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_result_year,
  output logic [3:0]          out_result_month,
  output logic [4:0]          out_result_day
);
  import cdd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_MOD  = 5'b00100,
    S_RUN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t     state_r;
  date_t      date_r;
  date_t      step_nxt;
  logic       month_mode_r;
  logic [17:0] steps_r;
  logic [32:0] prod_r;
  logic       out_valid_r;
  logic signed [15:0] out_year_r;
  logic [3:0] out_month_r;
  logic [4:0] out_day_r;

  logic        accept;
  logic        out_free;
  logic [3:0]  norm_month;
  logic [4:0]  norm_day;
  logic [15:0] ybias;
  logic [11:0] quot;
  logic [16:0] quot25;
  logic [16:0] rem_w;
  logic [5:0]  rem_b;
  logic [4:0]  m25_init;
  logic [17:0] count_w;
  logic [15:0] count16;
  logic [15:0] decade_sub;
  logic signed [15:0] year_nxt;
  logic [17:0] steps_nxt;
  logic        mode_nxt;
  state_t      start_state;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign norm_month = (in_start_month == 4'd0) ? MONTH_JAN :
                      (in_start_month > MONTH_DEC) ? MONTH_DEC : in_start_month;
  assign norm_day   = (in_start_day == 5'd0) ? DAY_FIRST : in_start_day;
  assign count_w    = {3'd0, in_count};
  assign count16    = {1'b0, in_count};
  assign decade_sub = {count16[12:0], 3'b000} + {count16[14:0], 1'b0};

  // offset the signed year to 0..65535, then residue via reciprocal multiply
  assign ybias  = date_r.year ^ 16'h8000;
  assign quot   = prod_r[32:RECIP25_SH];
  assign quot25 = {1'b0, quot, 4'b0000} + {2'b00, quot, 3'b000} + {5'd0, quot};
  assign rem_w  = {1'b0, ybias} - quot25;
  assign rem_b  = {1'b0, rem_w[4:0]} + M25_BIAS;
  assign m25_init = (rem_b >= M25_MOD) ? 5'(rem_b - M25_MOD) : rem_b[4:0];

  // starting values for an accepted item
  always_comb begin
    year_nxt    = in_start_year;
    steps_nxt   = count_w;
    mode_nxt    = 1'b0;
    start_state = S_DONE;
    unique case (op_t'(in_operation))
      OP_DAYS: begin
        start_state = S_INIT;
      end
      OP_WEEKS: begin
        steps_nxt   = {count_w[14:0], 3'b000} - count_w;
        start_state = S_INIT;
      end
      OP_MONTHS: begin
        mode_nxt    = 1'b1;
        start_state = S_INIT;
      end
      OP_YEARS: begin
        year_nxt = in_start_year - count16;
      end
      OP_DECADES: begin
        year_nxt = in_start_year - decade_sub;
      end
      OP_CENTURY: begin
        year_nxt = in_start_year - CENTURY;
      end
      OP_MILLENNIUM: begin
        year_nxt = in_start_year - MILLENNIUM;
      end
      OP_KEEP: begin
        year_nxt = in_start_year;
      end
      default: begin
        year_nxt = in_start_year;
      end
    endcase
  end

  cdd_step_unit u_step (
    .cur_i        (date_r),
    .month_mode_i (month_mode_r),
    .nxt_o        (step_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            date_r.year  <= year_nxt;
            date_r.month <= norm_month;
            date_r.day   <= norm_day;
            month_mode_r <= mode_nxt;
            steps_r      <= steps_nxt;
            state_r      <= start_state;
          end
        end
        S_INIT: begin
          prod_r  <= {17'd0, ybias} * {16'd0, RECIP25};
          state_r <= S_MOD;
        end
        S_MOD: begin
          date_r.m25 <= m25_init;
          state_r    <= S_RUN;
        end
        S_RUN: begin
          if (steps_r == 18'd0) begin
            state_r <= S_DONE;
          end else begin
            date_r  <= step_nxt;
            steps_r <= steps_r - 18'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
        out_year_r  <= date_r.year;
        out_month_r <= date_r.month;
        out_day_r   <= date_r.day;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_year  = out_year_r;
  assign out_result_month = out_month_r;
  assign out_result_day   = out_day_r;

endmodule

>>> rtl/cdd_checker.sv
// Checker: port-level assertions for the date decrement unit, bound to the top level.
module cdd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [15:0]  out_result_year,
  input logic [3:0]          out_result_month,
  input logic [4:0]          out_result_day
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_year) &&
      $stable(out_result_month) && $stable(out_result_day))
    else $error("result changed while stalled");

  // an accepted item leaves the input not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // results always carry a normalized month and a nonzero day
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_month != 4'd0) && (out_result_month <= 4'd12) &&
      (out_result_day != 5'd0))
    else $error("result date out of range");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind calendar_date_decrement_unit cdd_checker u_cdd_checker (.*);

>>> tb/tb.sv
// Testbench for calendar_date_decrement_unit: directed table plus random items, checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  localparam int RAND_ITEMS     = 80;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int DIR_ROWS       = 24;

  typedef struct packed {
    logic signed [15:0] yr;
    logic [3:0]         mo;
    logic [4:0]         dy;
  } date_res_t;

  typedef struct packed {
    op_t                op;
    logic [14:0]        cnt;
    logic signed [15:0] yr;
    logic [3:0]         mo;
    logic [4:0]         dy;
    bit                 typed;
    logic signed [15:0] eyr;
    logic [3:0]         emo;
    logic [4:0]         edy;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_operation;
  logic [14:0]        in_count;
  logic signed [15:0] in_start_year;
  logic [3:0]         in_start_month;
  logic [4:0]         in_start_day;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_result_year;
  logic [3:0]         out_result_month;
  logic [4:0]         out_result_day;

  date_res_t pending_dates[$];
  dir_row_t  dir_rows [DIR_ROWS];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        long_hold_req;

  calendar_date_decrement_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_count         (in_count),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] month_days(logic signed [15:0] y, logic [3:0] m);
    int s;
    bit leap;
    s    = y;
    leap = (s % 400 == 0) || ((s % 4 == 0) && (s % 100 != 0));
    case (m)
      MONTH_FEB:               return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic date_res_t back_date(logic [2:0] op, logic [14:0] cnt,
                                          logic signed [15:0] yr, logic [3:0] mo,
                                          logic [4:0] dy);
    date_res_t r;
    int        steps;
    logic [4:0] len;
    r.yr = yr;
    r.mo = (mo == 4'd0) ? MONTH_JAN : ((mo > MONTH_DEC) ? MONTH_DEC : mo);
    r.dy = (dy == 5'd0) ? DAY_FIRST : dy;
    case (op)
      OP_DAYS, OP_WEEKS: begin
        steps = (op == OP_WEEKS) ? int'(cnt) * 7 : int'(cnt);
        repeat (steps) begin
          if (r.dy <= DAY_FIRST) begin
            if (r.mo == MONTH_JAN) begin
              r.yr = r.yr - 16'sd1;
              r.mo = MONTH_DEC;
              r.dy = 5'd31;
            end else begin
              r.mo = r.mo - 4'd1;
              r.dy = month_days(r.yr, r.mo);
            end
          end else begin
            r.dy = r.dy - 5'd1;
          end
        end
      end
      OP_MONTHS: begin
        repeat (int'(cnt)) begin
          if (r.mo == MONTH_JAN) begin
            r.mo = MONTH_DEC;
            r.yr = r.yr - 16'sd1;
          end else begin
            r.mo = r.mo - 4'd1;
          end
          len = month_days(r.yr, r.mo);
          if (r.dy > len) r.dy = len;
        end
      end
      OP_YEARS:      r.yr = r.yr - 16'({1'b0, cnt});
      OP_DECADES:    r.yr = r.yr - 16'(int'(cnt) * 10);
      OP_CENTURY:    r.yr = r.yr - 16'sd100;
      OP_MILLENNIUM: r.yr = r.yr - 16'sd1000;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [14:0] cnt,
                           input logic signed [15:0] yr, input logic [3:0] mo,
                           input logic [4:0] dy, input bit typed, input date_res_t typed_res,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_count       <= cnt;
    in_start_year  <= yr;
    in_start_month <= mo;
    in_start_day   <= dy;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(typed ? typed_res : back_date(op, cnt, yr, mo, dy));
  endtask

  // sender
  initial begin
    int               i;
    int               k;
    int               burst_left;
    logic [2:0]       op_v;
    logic [14:0]      cnt_v;
    logic signed [15:0] yr_v;
    logic [3:0]       mo_v;
    logic [4:0]       dy_v;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_DAYS;
    in_count       = '0;
    in_start_year  = '0;
    in_start_month = MONTH_JAN;
    in_start_day   = DAY_FIRST;
    long_hold_req  = 1'b0;
    burst_left     = 0;
    dir_rows = '{
      '{OP_DAYS,       15'd0,     16'sd0,     4'd1,  5'd1,  1'b1, 16'sd0,     4'd1,  5'd1},
      '{OP_DAYS,       15'd1,     16'sh8000,  4'd1,  5'd1,  1'b1, 16'sd32767, 4'd12, 5'd31},
      '{OP_DAYS,       15'd1,     16'sd2000,  4'd3,  5'd1,  1'b1, 16'sd2000,  4'd2,  5'd29},
      '{OP_DAYS,       15'd1,     16'sd1900,  4'd3,  5'd1,  1'b1, 16'sd1900,  4'd2,  5'd28},
      '{OP_DAYS,       15'd1,     16'sd0,     4'd3,  5'd1,  1'b1, 16'sd0,     4'd2,  5'd29},
      '{OP_DAYS,       15'd1,     -16'sd4,    4'd3,  5'd1,  1'b1, -16'sd4,    4'd2,  5'd29},
      '{OP_DAYS,       15'd1,     -16'sd100,  4'd3,  5'd1,  1'b1, -16'sd100,  4'd2,  5'd28},
      '{OP_WEEKS,      15'd1,     16'sd2023,  4'd1,  5'd3,  1'b1, 16'sd2022,  4'd12, 5'd27},
      '{OP_MONTHS,     15'd1,     16'sd2001,  4'd3,  5'd31, 1'b1, 16'sd2001,  4'd2,  5'd28},
      '{OP_MONTHS,     15'd1,     16'sd2024,  4'd1,  5'd31, 1'b1, 16'sd2023,  4'd12, 5'd31},
      '{OP_YEARS,      15'd1,     16'sd2024,  4'd2,  5'd29, 1'b1, 16'sd2023,  4'd2,  5'd29},
      '{OP_DECADES,    15'd3,     16'sd2024,  4'd5,  5'd5,  1'b1, 16'sd1994,  4'd5,  5'd5},
      '{OP_CENTURY,    15'd32767, 16'sd2024,  4'd7,  5'd4,  1'b1, 16'sd1924,  4'd7,  5'd4},
      '{OP_MILLENNIUM, 15'd0,     16'sh8000,  4'd6,  5'd15, 1'b1, 16'sd31768, 4'd6,  5'd15},
      '{OP_KEEP,       15'd5,     16'sd2024,  4'd13, 5'd0,  1'b1, 16'sd2024,  4'd12, 5'd1},
      '{OP_DAYS,       15'd0,     16'sd100,   4'd0,  5'd31, 1'b1, 16'sd100,   4'd1,  5'd31},
      '{OP_DAYS,       15'd1,     16'sd2023,  4'd2,  5'd31, 1'b1, 16'sd2023,  4'd2,  5'd30},
      '{OP_YEARS,      15'd32767, 16'sd32767, 4'd6,  5'd30, 1'b1, 16'sd0,     4'd6,  5'd30},
      '{OP_MONTHS,     15'd0,     -16'sd1,    4'd14, 5'd0,  1'b1, -16'sd1,    4'd12, 5'd1},
      '{OP_DAYS,       15'd32767, 16'sd32767, 4'd12, 5'd31, 1'b0, 16'sd0,     4'd0,  5'd0},
      '{OP_WEEKS,      15'd32767, 16'sd32767, 4'd15, 5'd31, 1'b0, 16'sd0,     4'd0,  5'd0},
      '{OP_MONTHS,     15'd32767, 16'sh8000,  4'd1,  5'd31, 1'b0, 16'sd0,     4'd0,  5'd0},
      '{OP_DECADES,    15'd32767, 16'sd0,     4'd8,  5'd15, 1'b0, 16'sd0,     4'd0,  5'd0},
      '{OP_DAYS,       15'd365,   16'sd2024,  4'd1,  5'd1,  1'b0, 16'sd0,     4'd0,  5'd0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].op, dir_rows[i].cnt, dir_rows[i].yr, dir_rows[i].mo,
                dir_rows[i].dy, dir_rows[i].typed,
                date_res_t'{dir_rows[i].eyr, dir_rows[i].emo, dir_rows[i].edy}, pick_gap());
    end

    // pause until the directed items have all drained
    in_valid <= 1'b0;
    wait (pending_dates.size() == 0);
    @(posedge clk);

    long_hold_req = 1'b1;
    burst_left    = 8;
    for (i = 0; i < RAND_ITEMS; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30)      op_v = OP_DAYS;
      else if (k < 45) op_v = OP_WEEKS;
      else if (k < 70) op_v = OP_MONTHS;
      else             op_v = 3'($urandom_range(3, 7));
      k = $urandom_range(0, 19);
      case (op_v)
        OP_DAYS, OP_MONTHS:
          cnt_v = (k < 14) ? 15'($urandom_range(0, 40)) :
                  (k < 19) ? 15'($urandom_range(41, 400)) : 15'($urandom_range(401, 3000));
        OP_WEEKS:
          cnt_v = (k < 16) ? 15'($urandom_range(0, 10)) : 15'($urandom_range(11, 120));
        default:
          cnt_v = 15'($urandom);
      endcase
      k = $urandom_range(0, 9);
      if (k < 4)      yr_v = 16'($urandom);
      else if (k < 6) yr_v = 16'($urandom_range(0, 40) * 100) - 16'sd2000;
      else if (k < 8) yr_v = ($urandom_range(0, 1) == 1) ?
                             16'sh8000 + 16'($urandom_range(0, 3)) :
                             16'sd32767 - 16'($urandom_range(0, 3));
      else            yr_v = 16'($urandom_range(0, 1000) * 4) - 16'sd2000;
      mo_v = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(1, 12)) : 4'($urandom_range(0, 15));
      k = $urandom_range(0, 9);
      if (k < 6)      dy_v = 5'($urandom_range(1, 28));
      else if (k < 9) dy_v = 5'($urandom_range(29, 31));
      else            dy_v = 5'($urandom_range(0, 31));
      if (i == RAND_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait (pending_dates.size() == 0);
        @(posedge clk);
      end
      if (burst_left > 0) begin
        burst_left--;
        send_item(op_v, cnt_v, yr_v, mo_v, dy_v, 1'b0, '0, 0);
      end else begin
        send_item(op_v, cnt_v, yr_v, mo_v, dy_v, 1'b0, '0, pick_gap());
      end
    end
    in_valid <= 1'b0;

    wait (pending_dates.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // receiver
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    date_res_t exp_date;
    if (rst_n && out_valid && out_ready) begin
      if (pending_dates.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: year %0d month %0d day %0d",
                   out_result_year, out_result_month, out_result_day);
        mismatches++;
      end else begin
        exp_date = pending_dates.pop_front();
        if (out_result_year !== exp_date.yr || out_result_month !== exp_date.mo ||
            out_result_day !== exp_date.dy) begin
          if (mismatches < 10)
            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     exp_date.yr, exp_date.mo, exp_date.dy,
                     out_result_year, out_result_month, out_result_day);
          mismatches++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> calendar_date_decrement_unit.f
rtl/cdd_pkg.sv
rtl/cdd_step_unit.sv
rtl/calendar_date_decrement_unit.sv
rtl/cdd_checker.sv
tb/tb.sv
